@@ sv/bram_pkg.sv @@
// Package for the byte register ALU machine: command codes, field widths
// and the packed transfer types of the command and result channels.
// No dependencies.
package bram_pkg;

  // Field widths fixed by the command and result formats
  localparam int CMD_W    = 5;
  localparam int INDEX_W  = 5;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 4;

  // Byte that the set command writes into the accumulator
  localparam logic [DATA_W-1:0] BYTE_ONES = 8'hff;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MOV     = 5'd0;
  localparam logic [CMD_W-1:0] CMD_SETPTR  = 5'd1;
  localparam logic [CMD_W-1:0] CMD_LD      = 5'd2;
  localparam logic [CMD_W-1:0] CMD_LDA     = 5'd3;
  localparam logic [CMD_W-1:0] CMD_LDB     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_SHOW    = 5'd5;
  localparam logic [CMD_W-1:0] CMD_ADD_R1  = 5'd6;
  localparam logic [CMD_W-1:0] CMD_SUB_R1  = 5'd7;
  localparam logic [CMD_W-1:0] CMD_AND_R1  = 5'd8;
  localparam logic [CMD_W-1:0] CMD_OR_R1   = 5'd9;
  localparam logic [CMD_W-1:0] CMD_XOR_R1  = 5'd10;
  localparam logic [CMD_W-1:0] CMD_ADD_PTR = 5'd11;
  localparam logic [CMD_W-1:0] CMD_SUB_PTR = 5'd12;
  localparam logic [CMD_W-1:0] CMD_AND_PTR = 5'd13;
  localparam logic [CMD_W-1:0] CMD_OR_PTR  = 5'd14;
  localparam logic [CMD_W-1:0] CMD_XOR_PTR = 5'd15;
  localparam logic [CMD_W-1:0] CMD_COM     = 5'd16;
  localparam logic [CMD_W-1:0] CMD_NEG     = 5'd17;
  localparam logic [CMD_W-1:0] CMD_INC     = 5'd18;
  localparam logic [CMD_W-1:0] CMD_DEC     = 5'd19;
  localparam logic [CMD_W-1:0] CMD_SER     = 5'd20;
  localparam logic [CMD_W-1:0] CMD_CLR     = 5'd21;

  // One command transfer
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
    logic [DATA_W-1:0]  load_value;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic [INDEX_W-1:0]  pointer_value;
    logic [DATA_W-1:0]   pointed_byte;
    logic [STATUS_W-1:0] status_byte;
  } out_item_t;

endpackage

@@ sv/byte_register_alu_machine.sv @@
// Top level of the byte register ALU machine: register file, pointer,
// flags, single-pass execute stage and result register.
// Depends on bram_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------
//  in_     | input     | in_valid / in_ready   | bram_pkg::in_item_t
//  out_    | output    | out_valid / out_ready | bram_pkg::out_item_t
//
// One command is taken per cycle while the input is not stalled; in the execute
// stage, the register file read data (captured at the input transfer) meets
// the ALU and the write port. A show result appears the cycle after it retires.
// Synchronous reset clears the pointer, the flags, the per-entry valid bits
// of the register file (an invalid entry reads as zero) and both stages.
// Only a show command waiting for a full result register stalls the input.
module byte_register_alu_machine #(
  parameter int REG_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bram_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bram_pkg::out_item_t  out_data
);

  import bram_pkg::*;

  localparam int IDX_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int IDX_SPAN = 1 << INDEX_W;

  typedef logic [IDX_SPAN-1:0][IDX_W-1:0] wrap_lut_t;

  // Index field to register number, modulo the register count
  function automatic wrap_lut_t wrap_lut_f();
    wrap_lut_t lut;
    for (int i = 0; i < IDX_SPAN; i++) begin
      lut[i] = IDX_W'(i % REG_COUNT);
    end
    return lut;
  endfunction

  localparam wrap_lut_t WRAP_LUT = wrap_lut_f();

  // Register file storage and architectural state
  logic [DATA_W-1:0]    mem_r [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [DATA_W-1:0]    acc_r;
  logic [DATA_W-1:0]    opr_r;
  logic [IDX_W-1:0]     ptr_r;
  logic [IDX_W-1:0]     ptr_nxt;
  logic                 carry_r;
  logic                 borrow_r;
  logic                 zero_r;

  // Execute stage
  logic              ex_valid_r;
  logic              ex_valid_nxt;
  in_item_t          ex_item_r;
  logic [DATA_W-1:0] src_data_r;
  logic [DATA_W-1:0] ptr_data_r;

  // Result register
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;

  // Handshake and control
  logic              in_fire;
  logic              ex_is_show;
  logic              ex_go;
  logic              ex_fire;
  logic              out_load;
  logic [IDX_W-1:0]  rd_src_idx;
  logic [IDX_W-1:0]  ex_first_idx;

  // Execute stage datapath
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [DATA_W-1:0] wr_data;
  logic              flags_upd;
  logic              alu_carry;
  logic              alu_borrow;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] alu_opnd;
  logic [DATA_W:0]   alu_sum;
  logic [DATA_W:0]   alu_diff;

  // Flow control: only a show command can wait on the result register
  assign ex_is_show = (ex_item_r.cmd == CMD_SHOW);
  assign ex_go      = !ex_is_show || !out_valid_r || out_ready;
  assign ex_fire    = ex_valid_r && ex_go;
  assign in_ready   = !ex_valid_r || ex_go;
  assign in_fire    = in_valid && in_ready;
  assign out_load   = ex_fire && ex_is_show;

  assign rd_src_idx   = WRAP_LUT[in_data.second_index];
  assign ex_first_idx = WRAP_LUT[ex_item_r.first_index];

  // Pointer as seen by the next command, including a retiring setptr
  always_comb begin
    ptr_nxt = ptr_r;
    if (ex_fire && ex_item_r.cmd == CMD_SETPTR) begin
      ptr_nxt = ex_first_idx;
    end
  end

  // Second ALU operand: register 1 or the pointed register
  always_comb begin
    case (ex_item_r.cmd)
      CMD_ADD_PTR, CMD_SUB_PTR, CMD_AND_PTR, CMD_OR_PTR, CMD_XOR_PTR: begin
        alu_opnd = ptr_data_r;
      end
      default: begin
        alu_opnd = opr_r;
      end
    endcase
  end

  assign alu_sum  = {1'b0, acc_r} + {1'b0, alu_opnd};
  assign alu_diff = {1'b0, acc_r} - {1'b0, alu_opnd};

  // Command decode: register file write and ALU result
  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = ex_first_idx;
    wr_data    = ex_item_r.load_value;
    flags_upd  = 1'b0;
    alu_carry  = 1'b0;
    alu_borrow = 1'b0;
    alu_res    = '0;
    case (ex_item_r.cmd)
      CMD_MOV: begin
        wr_en   = 1'b1;
        wr_data = src_data_r;
      end
      CMD_LD: begin
        wr_en = 1'b1;
      end
      CMD_LDA: begin
        wr_en  = 1'b1;
        wr_idx = '0;
      end
      CMD_LDB: begin
        wr_en  = 1'b1;
        wr_idx = IDX_W'(1);
      end
      CMD_ADD_R1, CMD_ADD_PTR: begin
        flags_upd = 1'b1;
        alu_res   = alu_sum[DATA_W-1:0];
        alu_carry = alu_sum[DATA_W];
      end
      CMD_SUB_R1, CMD_SUB_PTR: begin
        flags_upd  = 1'b1;
        alu_res    = alu_diff[DATA_W-1:0];
        alu_borrow = alu_diff[DATA_W];
      end
      CMD_AND_R1, CMD_AND_PTR: begin
        flags_upd = 1'b1;
        alu_res   = acc_r & alu_opnd;
      end
      CMD_OR_R1, CMD_OR_PTR: begin
        flags_upd = 1'b1;
        alu_res   = acc_r | alu_opnd;
      end
      CMD_XOR_R1, CMD_XOR_PTR: begin
        flags_upd = 1'b1;
        alu_res   = acc_r ^ alu_opnd;
      end
      CMD_COM: begin
        flags_upd = 1'b1;
        alu_res   = ~acc_r;
      end
      CMD_NEG: begin
        flags_upd = 1'b1;
        alu_res   = DATA_W'(0) - acc_r;
      end
      CMD_INC: begin
        flags_upd = 1'b1;
        alu_res   = acc_r + DATA_W'(1);
      end
      CMD_DEC: begin
        flags_upd = 1'b1;
        alu_res   = acc_r - DATA_W'(1);
      end
      CMD_SER: begin
        flags_upd = 1'b1;
        alu_res   = BYTE_ONES;
      end
      CMD_CLR: begin
        flags_upd = 1'b1;
        alu_res   = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    // Every ALU command writes its result back to the accumulator
    if (flags_upd) begin
      wr_en   = 1'b1;
      wr_idx  = '0;
      wr_data = alu_res;
    end
  end

  // Register file array; written only when the command retires
  always_ff @(posedge clk) begin
    if (ex_fire && wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  // Per-entry valid bits, so that unwritten registers read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ex_fire && wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // Accumulator and operand register copies, kept alongside the array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      opr_r <= '0;
    end else if (ex_fire && wr_en) begin
      if (wr_idx == '0) begin
        acc_r <= wr_data;
      end
      if (wr_idx == IDX_W'(1)) begin
        opr_r <= wr_data;
      end
    end
  end

  // Pointer and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      carry_r  <= 1'b0;
      borrow_r <= 1'b0;
      zero_r   <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      if (ex_fire && flags_upd) begin
        carry_r  <= alu_carry;
        borrow_r <= alu_borrow;
        zero_r   <= (alu_res == '0);
      end
    end
  end

  // Execute stage valid
  always_comb begin
    ex_valid_nxt = ex_valid_r;
    if (in_fire) begin
      ex_valid_nxt = 1'b1;
    end else if (ex_fire) begin
      ex_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else begin
      ex_valid_r <= ex_valid_nxt;
    end
  end

  // Capture the command and its two register reads on the input transfer.
  // A write retiring at the same edge is forwarded into the read data.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_item_r <= in_data;
      if (ex_fire && wr_en && wr_idx == rd_src_idx) begin
        src_data_r <= wr_data;
      end else begin
        src_data_r <= valid_r[rd_src_idx] ? mem_r[rd_src_idx] : '0;
      end
      if (ex_fire && wr_en && wr_idx == ptr_nxt) begin
        ptr_data_r <= wr_data;
      end else begin
        ptr_data_r <= valid_r[ptr_nxt] ? mem_r[ptr_nxt] : '0;
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pointer_value <= INDEX_W'(ptr_r);
      out_data_r.pointed_byte  <= ptr_data_r;
      out_data_r.status_byte   <= {carry_r, borrow_r, zero_r, 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new command never overwrites one that is still waiting to retire.
  a_no_ex_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!ex_valid_r || ex_fire))
    else $error("execute stage overwritten while busy");

  // Only a show command may hold the execute stage.
  a_stall_only_show: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_valid_r && !ex_go) |-> ex_is_show)
    else $error("non-show command stalled");

  // A result is loaded only into a free or draining result register.
  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // The pointer always names an existing register.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ptr_r} < (IDX_W + 1)'(REG_COUNT))
    else $error("pointer beyond register file");

  // The accumulator copy agrees with register 0 of the array.
  a_acc_copy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r == (valid_r[0] ? mem_r[0] : '0))
    else $error("accumulator copy out of step with register file");

endmodule
